// ===== sv/vvc_pkg.sv =====
// Shared types, register indexes and helpers for the view volume cull test.
`default_nettype none

package vvc_pkg;

  // Default and limits of the coordinate width
  localparam int COORD_BITS_DEFAULT = 16;
  localparam int FIELD_W            = 16;

  // Cull volume geometry
  localparam int NUM_PLANES   = 6;
  localparam int NUM_AXES     = 3;
  localparam int NORMAL_SHIFT = 14;
  localparam int RADIUS_W     = 15;
  localparam int REACH_W      = FIELD_W + 1;
  localparam int REACH_SQ_W   = 2 * REACH_W;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int PLANE_IDX_W = 3;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CULL_KIND    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PLANE_LEFT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PLANE_RIGHT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PLANE_BOTTOM = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PLANE_TOP    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PLANE_NEAR   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_PLANE_FAR    = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPHERE       = 3'd7;

  // Cull kinds and query modes
  localparam logic KIND_FRUSTUM = 1'b0;
  localparam logic KIND_SPHERE  = 1'b1;
  localparam logic MODE_SPHERE  = 1'b0;
  localparam logic MODE_BOX     = 1'b1;

  // One frustum plane, laid out as in its register
  typedef struct packed {
    logic signed [FIELD_W-1:0] w;
    logic signed [FIELD_W-1:0] nz;
    logic signed [FIELD_W-1:0] ny;
    logic signed [FIELD_W-1:0] nx;
  } plane_t;

  // Light sphere, raw fields as in its register
  typedef struct packed {
    logic [FIELD_W-1:0] sr;
    logic [FIELD_W-1:0] sz;
    logic [FIELD_W-1:0] sy;
    logic [FIELD_W-1:0] sx;
  } sphere_t;

  typedef struct packed {
    logic                     cull_kind;
    plane_t [NUM_PLANES-1:0]  plane;
    sphere_t                  sphere;
  } cfg_t;

  // Query payload as it arrives on the input channel
  typedef struct packed {
    logic                mode;
    logic [FIELD_W-1:0]  center_x;
    logic [FIELD_W-1:0]  center_y;
    logic [FIELD_W-1:0]  center_z;
    logic [RADIUS_W-1:0] bound_radius;
    logic [FIELD_W-1:0]  lo_x;
    logic [FIELD_W-1:0]  lo_y;
    logic [FIELD_W-1:0]  lo_z;
    logic [FIELD_W-1:0]  hi_x;
    logic [FIELD_W-1:0]  hi_y;
    logic [FIELD_W-1:0]  hi_z;
  } query_t;

  // Internal width of a decoded coordinate; wide settings read as non-negative
  function automatic int coord_width(input int cb);
    return (cb > FIELD_W) ? FIELD_W + 1 : cb;
  endfunction

  // Normal component of a plane along one axis
  function automatic logic signed [FIELD_W-1:0] normal_of(input plane_t p, input int k);
    logic signed [FIELD_W-1:0] n;
    n = p.nx;
    if (k == 1) n = p.ny;
    if (k == 2) n = p.nz;
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== sv/vvc_channels.sv =====
// Handshake channels for queries and cull results.
`default_nettype none

interface vvc_query_if;
  import vvc_pkg::*;
  logic                valid;
  logic                ready;
  logic                mode;
  logic [FIELD_W-1:0]  center_x;
  logic [FIELD_W-1:0]  center_y;
  logic [FIELD_W-1:0]  center_z;
  logic [RADIUS_W-1:0] bound_radius;
  logic [FIELD_W-1:0]  lo_x;
  logic [FIELD_W-1:0]  lo_y;
  logic [FIELD_W-1:0]  lo_z;
  logic [FIELD_W-1:0]  hi_x;
  logic [FIELD_W-1:0]  hi_y;
  logic [FIELD_W-1:0]  hi_z;

  modport source (
    output valid, mode, center_x, center_y, center_z, bound_radius,
           lo_x, lo_y, lo_z, hi_x, hi_y, hi_z,
    input  ready
  );
  modport sink (
    input  valid, mode, center_x, center_y, center_z, bound_radius,
           lo_x, lo_y, lo_z, hi_x, hi_y, hi_z,
    output ready
  );
endinterface

interface vvc_result_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface

`default_nettype wire

// ===== sv/vvc_cfg_regs.sv =====
// Configuration register file: cull kind, six planes and the light sphere.
`default_nettype none

module vvc_cfg_regs
  import vvc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                        cfg
);

  // Write one register per enabled cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CULL_KIND: begin
          cfg.cull_kind <= cfg_data[0];
        end
        REG_SPHERE: begin
          cfg.sphere <= sphere_t'(cfg_data);
        end
        default: begin
          cfg.plane[PLANE_IDX_W'(cfg_index - REG_PLANE_LEFT)] <= plane_t'(cfg_data);
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/vvc_prep.sv =====
// First stage: decode coordinates, pick plane corners and sphere distances.
`default_nettype none

module vvc_prep
  import vvc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT,
  localparam int CW = coord_width(COORD_BITS)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire query_t              q,
  input  wire cfg_t                cfg,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     box,
  output logic [RADIUS_W-1:0]      r,
  output logic signed [CW-1:0]     pt [NUM_PLANES][NUM_AXES],
  output logic signed [CW:0]       delta [NUM_AXES],
  output logic [REACH_W-1:0]       reach
);

  localparam int NUM_RAW = 4 * NUM_AXES;

  logic [FIELD_W-1:0]      raw [NUM_RAW];
  logic signed [CW-1:0]    crd [NUM_RAW];
  logic signed [CW-1:0]    pt_next [NUM_PLANES][NUM_AXES];
  logic signed [CW:0]      delta_next [NUM_AXES];
  logic [REACH_W-1:0]      reach_next;

  // Order: center, lo, hi, light sphere center
  assign raw[0]  = q.center_x;
  assign raw[1]  = q.center_y;
  assign raw[2]  = q.center_z;
  assign raw[3]  = q.lo_x;
  assign raw[4]  = q.lo_y;
  assign raw[5]  = q.lo_z;
  assign raw[6]  = q.hi_x;
  assign raw[7]  = q.hi_y;
  assign raw[8]  = q.hi_z;
  assign raw[9]  = cfg.sphere.sx;
  assign raw[10] = cfg.sphere.sy;
  assign raw[11] = cfg.sphere.sz;

  // Decode coordinates: sign from bit COORD_BITS-1, or plain 16 bits when wider
  for (genvar i = 0; i < NUM_RAW; i++) begin : g_coord
    if (COORD_BITS > FIELD_W) begin : g_wide
      assign crd[i] = signed'({1'b0, raw[i]});
    end else begin : g_narrow
      assign crd[i] = signed'(raw[i][CW-1:0]);
    end
  end

  // Select the positive vertex per plane, or the center for a sphere query
  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        if (q.mode == MODE_BOX) begin
          pt_next[p][k] = (normal_of(cfg.plane[p], k) >= 0) ? crd[6 + k] : crd[3 + k];
        end else begin
          pt_next[p][k] = crd[k];
        end
      end
    end
  end

  // Per-axis distance to the light sphere center, gap to the box for box queries
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      if (q.mode == MODE_BOX) begin
        if (crd[9 + k] < crd[3 + k]) begin
          delta_next[k] = (CW + 1)'(crd[3 + k]) - (CW + 1)'(crd[9 + k]);
        end else if (crd[9 + k] > crd[6 + k]) begin
          delta_next[k] = (CW + 1)'(crd[9 + k]) - (CW + 1)'(crd[6 + k]);
        end else begin
          delta_next[k] = '0;
        end
      end else begin
        delta_next[k] = (CW + 1)'(crd[k]) - (CW + 1)'(crd[9 + k]);
      end
    end
  end

  // Combined radius for sphere queries, light radius alone for boxes
  assign reach_next = (q.mode == MODE_BOX) ? REACH_W'(cfg.sphere.sr)
                                           : REACH_W'(cfg.sphere.sr) + REACH_W'(q.bound_radius);

  assign in_ready = !out_valid || out_ready;

  // Advance the stage whenever the next one can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      box   <= q.mode;
      r     <= q.bound_radius;
      pt    <= pt_next;
      delta <= delta_next;
      reach <= reach_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/vvc_mult.sv =====
// Second stage: plane dot-product terms and squared distances.
`default_nettype none

module vvc_mult
  import vvc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT,
  localparam int CW = coord_width(COORD_BITS),
  localparam int PW = FIELD_W + CW,
  localparam int SW = 2 * CW + 2
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_box,
  input  wire logic [RADIUS_W-1:0] in_r,
  input  wire logic signed [CW-1:0] pt [NUM_PLANES][NUM_AXES],
  input  wire logic signed [CW:0]  delta [NUM_AXES],
  input  wire logic [REACH_W-1:0]  reach,
  input  wire cfg_t                cfg,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     box,
  output logic [RADIUS_W-1:0]      r,
  output logic signed [PW-1:0]     prod [NUM_PLANES][NUM_AXES],
  output logic [SW-1:0]            sq [NUM_AXES],
  output logic [REACH_SQ_W-1:0]    reach_sq
);

  logic signed [PW-1:0] prod_next [NUM_PLANES][NUM_AXES];
  logic signed [SW-1:0] sq_signed [NUM_AXES];

  // Multiply normals by the chosen points, square the distances
  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        prod_next[p][k] = PW'(normal_of(cfg.plane[p], k)) * PW'(pt[p][k]);
      end
    end
    for (int k = 0; k < NUM_AXES; k++) begin
      sq_signed[k] = SW'(delta[k]) * SW'(delta[k]);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Capture products on a transaction into this stage
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      box      <= in_box;
      r        <= in_r;
      prod     <= prod_next;
      reach_sq <= REACH_SQ_W'(reach) * REACH_SQ_W'(reach);
      for (int k = 0; k < NUM_AXES; k++) begin
        sq[k] <= unsigned'(sq_signed[k]);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/vvc_reduce.sv =====
// Final stage: sum plane terms, compare distances, register the verdict.
`default_nettype none

module vvc_reduce
  import vvc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT,
  localparam int CW = coord_width(COORD_BITS),
  localparam int PW = FIELD_W + CW,
  localparam int SW = 2 * CW + 2,
  localparam int OFS_W = FIELD_W + NORMAL_SHIFT,
  localparam int ACC_W = ((PW > OFS_W) ? PW : OFS_W) + 3,
  localparam int D2_W = SW + 2,
  localparam int CMP_W = (D2_W > REACH_SQ_W) ? D2_W : REACH_SQ_W
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_box,
  input  wire logic [RADIUS_W-1:0]   in_r,
  input  wire logic signed [PW-1:0]  prod [NUM_PLANES][NUM_AXES],
  input  wire logic [SW-1:0]         sq [NUM_AXES],
  input  wire logic [REACH_SQ_W-1:0] reach_sq,
  input  wire cfg_t                  cfg,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       visible
);

  logic signed [ACC_W-1:0] acc [NUM_PLANES];
  logic signed [ACC_W-1:0] bias;
  logic [NUM_PLANES-1:0]   fail;
  logic [CMP_W-1:0]        d2;
  logic                    sph_vis;
  logic                    visible_next;

  // Sphere queries shift the threshold by the radius scaled to normal units
  assign bias = (in_box == MODE_BOX) ? '0 : (ACC_W'(in_r) <<< NORMAL_SHIFT);

  // A plane culls when the biased signed distance is negative
  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      acc[p] = ACC_W'(prod[p][0]) + ACC_W'(prod[p][1]) + ACC_W'(prod[p][2])
             + (ACC_W'(cfg.plane[p].w) <<< NORMAL_SHIFT) + bias;
      fail[p] = acc[p][ACC_W-1];
    end
  end

  // Squared distance against the squared reach
  assign d2      = CMP_W'(sq[0]) + CMP_W'(sq[1]) + CMP_W'(sq[2]);
  assign sph_vis = d2 <= CMP_W'(reach_sq);

  assign visible_next = (cfg.cull_kind == KIND_SPHERE) ? sph_vis : ~|fail;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Hold the result until the output transaction completes
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      visible <= visible_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/view_volume_cull_test_unit.sv =====
// Top level of the view volume cull test.
`default_nettype none

// Answers whether a bounding sphere or axis-aligned box may be visible against
// a configured cull volume (six frustum planes or a light sphere). One query is
// accepted per clock while the pipe is not stalled, and its verdict reaches the
// result channel through its register stages: one decodes coordinates and
// picks corners, one holds the normal and distance products, and one holds the
// summed and compared verdict. Each stage holds its transaction while the next
// one is full, so a stalled result channel stops the pipe without loss and an
// empty stage lets a new query in. Configuration writes take effect at once and
// are meant to be made while no query is in flight.
module view_volume_cull_test_unit
  import vvc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  vvc_query_if.sink                   query,
  vvc_result_if.source                result,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = coord_width(COORD_BITS);
  localparam int PW = FIELD_W + CW;
  localparam int SW = 2 * CW + 2;

  cfg_t   cfg;
  query_t q;

  logic                    a_valid, a_ready, a_box;
  logic [RADIUS_W-1:0]     a_r;
  logic signed [CW-1:0]    a_pt [NUM_PLANES][NUM_AXES];
  logic signed [CW:0]      a_delta [NUM_AXES];
  logic [REACH_W-1:0]      a_reach;

  logic                    b_valid, b_ready, b_box;
  logic [RADIUS_W-1:0]     b_r;
  logic signed [PW-1:0]    b_prod [NUM_PLANES][NUM_AXES];
  logic [SW-1:0]           b_sq [NUM_AXES];
  logic [REACH_SQ_W-1:0]   b_reach_sq;

  // Gather the query payload
  assign q.mode         = query.mode;
  assign q.center_x     = query.center_x;
  assign q.center_y     = query.center_y;
  assign q.center_z     = query.center_z;
  assign q.bound_radius = query.bound_radius;
  assign q.lo_x         = query.lo_x;
  assign q.lo_y         = query.lo_y;
  assign q.lo_z         = query.lo_z;
  assign q.hi_x         = query.hi_x;
  assign q.hi_y         = query.hi_y;
  assign q.hi_z         = query.hi_z;

  vvc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vvc_prep #(.COORD_BITS(COORD_BITS)) u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (query.valid),
    .in_ready  (query.ready),
    .q         (q),
    .cfg       (cfg),
    .out_valid (a_valid),
    .out_ready (a_ready),
    .box       (a_box),
    .r         (a_r),
    .pt        (a_pt),
    .delta     (a_delta),
    .reach     (a_reach)
  );

  vvc_mult #(.COORD_BITS(COORD_BITS)) u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_valid),
    .in_ready  (a_ready),
    .in_box    (a_box),
    .in_r      (a_r),
    .pt        (a_pt),
    .delta     (a_delta),
    .reach     (a_reach),
    .cfg       (cfg),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .box       (b_box),
    .r         (b_r),
    .prod      (b_prod),
    .sq        (b_sq),
    .reach_sq  (b_reach_sq)
  );

  vvc_reduce #(.COORD_BITS(COORD_BITS)) u_reduce (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_valid),
    .in_ready  (b_ready),
    .in_box    (b_box),
    .in_r      (b_r),
    .prod      (b_prod),
    .sq        (b_sq),
    .reach_sq  (b_reach_sq),
    .cfg       (cfg),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .visible   (result.visible)
  );

endmodule

`default_nettype wire

// ===== verif/view_volume_cull_test_unit_test.sv =====
// Testbench for the view volume cull test: directed and random queries checked against a predictor.
`timescale 1ns / 100ps

module view_volume_cull_test_unit_test;
  import vvc_pkg::*;

  localparam int COORD_BITS  = COORD_BITS_DEFAULT;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 8;
  localparam int UNIT        = 256;
  localparam int NORMAL_ONE  = 1 << NORMAL_SHIFT;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_profile_t;
  typedef enum int {VOL_FORMED, VOL_RANDOM, VOL_EXTREME} volume_style_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  vvc_query_if  query_ch ();
  vvc_result_if result_ch ();

  view_volume_cull_test_unit #(.COORD_BITS(COORD_BITS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .query     (query_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the cull volume registers
  logic    kind_q;
  plane_t  plane_q [NUM_PLANES];
  sphere_t sphere_q;

  bit   expected_visible [$];
  int   failures = 0;
  int   send_idle_pct = 0;
  int   result_stall_pct = 0;
  logic result_hold = 1'b0;
  int   cycle_count;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Decode one Q8.8 coordinate at the configured width
  function automatic longint coord_value(input logic [FIELD_W-1:0] raw);
    longint v;
    if (COORD_BITS > FIELD_W) return longint'({48'd0, raw});
    v = longint'({48'd0, raw}) & ((longint'(1) <<< COORD_BITS) - 1);
    if (v[COORD_BITS-1]) v = v - (longint'(1) <<< COORD_BITS);
    return v;
  endfunction

  // Compute the verdict for one query against the mirrored cull volume
  function automatic bit predict_visible(input query_t q);
    longint c[3], lo[3], hi[3], s[3], nrm[3];
    longint r, sr, acc, d2, reach, gap;
    bit     seen;
    c[0]  = coord_value(q.center_x);
    c[1]  = coord_value(q.center_y);
    c[2]  = coord_value(q.center_z);
    lo[0] = coord_value(q.lo_x);
    lo[1] = coord_value(q.lo_y);
    lo[2] = coord_value(q.lo_z);
    hi[0] = coord_value(q.hi_x);
    hi[1] = coord_value(q.hi_y);
    hi[2] = coord_value(q.hi_z);
    r     = longint'({49'd0, q.bound_radius});
    seen  = 1'b1;
    if (kind_q == KIND_SPHERE) begin
      s[0] = coord_value(sphere_q.sx);
      s[1] = coord_value(sphere_q.sy);
      s[2] = coord_value(sphere_q.sz);
      sr   = longint'({48'd0, sphere_q.sr});
      d2   = 0;
      if (q.mode == MODE_SPHERE) begin
        reach = sr + r;
        for (int k = 0; k < NUM_AXES; k++) d2 += (c[k] - s[k]) * (c[k] - s[k]);
        seen = (d2 <= reach * reach);
      end else begin
        // Inverted boxes are taken as they come
        for (int k = 0; k < NUM_AXES; k++) begin
          gap = 0;
          if (s[k] < lo[k]) gap = lo[k] - s[k];
          else if (s[k] > hi[k]) gap = s[k] - hi[k];
          d2 += gap * gap;
        end
        seen = (d2 <= sr * sr);
      end
    end else begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        nrm[0] = longint'($signed(plane_q[p].nx));
        nrm[1] = longint'($signed(plane_q[p].ny));
        nrm[2] = longint'($signed(plane_q[p].nz));
        acc    = longint'($signed(plane_q[p].w)) * NORMAL_ONE;
        for (int k = 0; k < NUM_AXES; k++) begin
          if (q.mode == MODE_SPHERE) acc += nrm[k] * c[k];
          else acc += nrm[k] * ((nrm[k] >= 0) ? hi[k] : lo[k]);
        end
        if (q.mode == MODE_SPHERE) begin
          if (acc < -(r * NORMAL_ONE)) seen = 1'b0;
        end else if (acc < 0) begin
          seen = 1'b0;
        end
      end
    end
    return seen;
  endfunction

  // Fill every field with noise; callers overwrite the fields in use
  function automatic query_t junk_query();
    query_t q;
    q.mode         = 1'($urandom);
    q.center_x     = 16'($urandom);
    q.center_y     = 16'($urandom);
    q.center_z     = 16'($urandom);
    q.bound_radius = 15'($urandom);
    q.lo_x         = 16'($urandom);
    q.lo_y         = 16'($urandom);
    q.lo_z         = 16'($urandom);
    q.hi_x         = 16'($urandom);
    q.hi_y         = 16'($urandom);
    q.hi_z         = 16'($urandom);
    return q;
  endfunction

  function automatic query_t sphere_query(input int cx, input int cy, input int cz,
                                          input int r);
    query_t q;
    q              = junk_query();
    q.mode         = MODE_SPHERE;
    q.center_x     = 16'(cx);
    q.center_y     = 16'(cy);
    q.center_z     = 16'(cz);
    q.bound_radius = 15'(r);
    return q;
  endfunction

  function automatic query_t box_query(input int lx, input int ly, input int lz,
                                       input int hx, input int hy, input int hz);
    query_t q;
    q      = junk_query();
    q.mode = MODE_BOX;
    q.lo_x = 16'(lx);
    q.lo_y = 16'(ly);
    q.lo_z = 16'(lz);
    q.hi_x = 16'(hx);
    q.hi_y = 16'(hy);
    q.hi_z = 16'(hz);
    return q;
  endfunction

  function automatic plane_t make_plane(input int nx, input int ny, input int nz, input int w);
    plane_t p;
    p.nx = 16'(nx);
    p.ny = 16'(ny);
    p.nz = 16'(nz);
    p.w  = 16'(w);
    return p;
  endfunction

  function automatic int near_coord();
    return int'($urandom_range(0, 8191)) - 4096;
  endfunction

  function automatic logic [FIELD_W-1:0] extreme_field();
    case ($urandom_range(5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'h4000;
      default: return 16'hC000;
    endcase
  endfunction

  // Mostly sane geometry near the origin, some full-range noise
  function automatic query_t random_query();
    query_t q;
    int     a, b, lo[3], hi[3];
    bit     inverted;
    if ($urandom_range(99) < 20) return junk_query();
    if ($urandom_range(1) == 0)
      return sphere_query(near_coord(), near_coord(), near_coord(), $urandom_range(0, 2047));
    inverted = ($urandom_range(9) == 0);
    for (int k = 0; k < NUM_AXES; k++) begin
      a = near_coord();
      b = near_coord();
      lo[k] = (!inverted && a > b) ? b : a;
      hi[k] = (!inverted && a > b) ? a : b;
    end
    q = box_query(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    return q;
  endfunction

  function automatic plane_t random_plane(input volume_style_t style);
    case (style)
      VOL_FORMED:
        return make_plane(int'($urandom_range(0, 32767)) - 16384,
                          int'($urandom_range(0, 32767)) - 16384,
                          int'($urandom_range(0, 32767)) - 16384,
                          int'($urandom_range(0, 4095)) - 1024);
      VOL_RANDOM:
        return plane_t'({$urandom, $urandom});
      default:
        return plane_t'({extreme_field(), extreme_field(), extreme_field(), extreme_field()});
    endcase
  endfunction

  function automatic sphere_t random_sphere(input volume_style_t style);
    sphere_t s;
    case (style)
      VOL_FORMED: begin
        s.sx = 16'(int'($urandom_range(0, 4095)) - 2048);
        s.sy = 16'(int'($urandom_range(0, 4095)) - 2048);
        s.sz = 16'(int'($urandom_range(0, 4095)) - 2048);
        s.sr = 16'($urandom_range(0, 4096));
      end
      VOL_RANDOM:
        s = sphere_t'({$urandom, $urandom});
      default:
        s = sphere_t'({extreme_field(), extreme_field(), extreme_field(), extreme_field()});
    endcase
    return s;
  endfunction

  // Drive one register write and track it in the mirror
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_CULL_KIND) kind_q = data[0];
    else if (idx == REG_SPHERE) sphere_q = sphere_t'(data);
    else plane_q[idx - REG_PLANE_LEFT] = plane_t'(data);
    @(posedge clk);
  endtask

  task automatic load_cull_volume(input logic kind, input plane_t pl [NUM_PLANES],
                                  input sphere_t sph);
    write_reg(REG_CULL_KIND, CFG_DATA_W'(kind));
    for (int p = 0; p < NUM_PLANES; p++)
      write_reg(REG_PLANE_LEFT + CFG_INDEX_W'(p), pl[p]);
    write_reg(REG_SPHERE, sph);
    cfg_we <= 1'b0;
  endtask

  task automatic random_cull_volume(input logic kind, input volume_style_t style);
    plane_t pl [NUM_PLANES];
    for (int p = 0; p < NUM_PLANES; p++) pl[p] = random_plane(style);
    load_cull_volume(kind, pl, random_sphere(style));
  endtask

  task automatic set_idling(input idle_profile_t profile);
    case (profile)
      IDLE_NONE:     begin send_idle_pct = 0;  result_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 77; result_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  result_stall_pct = 77; end
      default:       begin send_idle_pct = 35; result_stall_pct = 35; end
    endcase
  endtask

  // Offer one query, hold it until accepted, then log its verdict
  task automatic send_query(input query_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      query_ch.valid <= 1'b0;
      @(posedge clk);
    end
    query_ch.valid        <= 1'b1;
    query_ch.mode         <= q.mode;
    query_ch.center_x     <= q.center_x;
    query_ch.center_y     <= q.center_y;
    query_ch.center_z     <= q.center_z;
    query_ch.bound_radius <= q.bound_radius;
    query_ch.lo_x         <= q.lo_x;
    query_ch.lo_y         <= q.lo_y;
    query_ch.lo_z         <= q.lo_z;
    query_ch.hi_x         <= q.hi_x;
    query_ch.hi_y         <= q.hi_y;
    query_ch.hi_z         <= q.hi_z;
    @(posedge clk);
    while (!query_ch.ready) @(posedge clk);
    expected_visible = {expected_visible, predict_visible(q)};
  endtask

  // Drop valid and wait until every verdict is back
  task automatic wait_for_results();
    query_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_visible.size() != 0) @(posedge clk);
  endtask

  // Reset volume is six zero planes: nothing may be culled
  task automatic test_zero_planes();
    set_idling(IDLE_NONE);
    send_query(sphere_query(-32768, 32767, -32768, 0));
    send_query(box_query(32767, 32767, 32767, -32768, -32768, -32768));
    send_query(junk_query());
    wait_for_results();
  endtask

  // Cube of +/-10 units: touching, straddling, inverted and extreme queries
  task automatic test_frustum_cube();
    plane_t pl [NUM_PLANES];
    sphere_t sph;
    pl[0] = make_plane(NORMAL_ONE, 0, 0, 10 * UNIT);
    pl[1] = make_plane(-NORMAL_ONE, 0, 0, 10 * UNIT);
    pl[2] = make_plane(0, NORMAL_ONE, 0, 10 * UNIT);
    pl[3] = make_plane(0, -NORMAL_ONE, 0, 10 * UNIT);
    pl[4] = make_plane(0, 0, NORMAL_ONE, 10 * UNIT);
    pl[5] = make_plane(0, 0, -NORMAL_ONE, 10 * UNIT);
    sph   = sphere_t'({$urandom, $urandom});
    load_cull_volume(KIND_FRUSTUM, pl, sph);
    send_query(sphere_query(0, 0, 0, 0));
    send_query(sphere_query(12 * UNIT, 0, 0, 2 * UNIT));
    send_query(sphere_query(12 * UNIT, 0, 0, 2 * UNIT - 1));
    send_query(sphere_query(-32768, 0, 0, 32767));
    send_query(sphere_query(32767, -32768, 32767, 0));
    send_query(box_query(-UNIT, -UNIT, -UNIT, UNIT, UNIT, UNIT));
    send_query(box_query(11 * UNIT, 0, 0, 12 * UNIT, UNIT, UNIT));
    send_query(box_query(9 * UNIT, 0, 0, 11 * UNIT, UNIT, UNIT));
    send_query(box_query(5 * UNIT, 0, 0, -5 * UNIT, UNIT, UNIT));
    send_query(box_query(20 * UNIT, 0, 0, -20 * UNIT, UNIT, UNIT));
    send_query(box_query(-32768, -32768, -32768, 32767, 32767, 32767));
    send_query(box_query(32767, 32767, 32767, 32767, 32767, 32767));
    wait_for_results();
  endtask

  // Most negative and most positive plane fields
  task automatic test_extreme_planes();
    plane_t pl [NUM_PLANES];
    pl[0] = plane_t'({16'h8000, 16'h8000, 16'h8000, 16'h8000});
    pl[1] = plane_t'({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
    for (int p = 2; p < NUM_PLANES; p++) pl[p] = '0;
    load_cull_volume(KIND_FRUSTUM, pl, '0);
    send_query(sphere_query(-32768, -32768, -32768, 32767));
    send_query(sphere_query(32767, 32767, 32767, 0));
    send_query(box_query(-32768, -32768, -32768, 32767, 32767, 32767));
    wait_for_results();
  endtask

  // Light sphere: exact touching, inverted boxes, extreme register values
  task automatic test_light_sphere();
    plane_t pl [NUM_PLANES];
    sphere_t sph;
    for (int p = 0; p < NUM_PLANES; p++) pl[p] = random_plane(VOL_RANDOM);
    sph = '0;
    sph.sr = 16'(10 * UNIT);
    load_cull_volume(KIND_SPHERE, pl, sph);
    send_query(sphere_query(12 * UNIT, 0, 0, 2 * UNIT));
    send_query(sphere_query(12 * UNIT, 0, 0, 2 * UNIT - 1));
    send_query(box_query(10 * UNIT, -UNIT, -UNIT, 11 * UNIT, UNIT, UNIT));
    send_query(box_query(10 * UNIT + 1, -UNIT, -UNIT, 11 * UNIT, UNIT, UNIT));
    send_query(box_query(5 * UNIT, 0, 0, -5 * UNIT, 0, 0));
    send_query(box_query(20 * UNIT, 0, 0, -20 * UNIT, 0, 0));
    wait_for_results();
    sph = sphere_t'({16'hFFFF, 16'h8000, 16'h8000, 16'h8000});
    load_cull_volume(KIND_SPHERE, pl, sph);
    send_query(sphere_query(32767, 32767, 32767, 32767));
    send_query(box_query(-32768, -32768, -32768, 32767, 32767, 32767));
    wait_for_results();
  endtask

  // Hold the result side off long enough to fill the pipe, then pause the sender
  task automatic test_backpressure();
    set_idling(IDLE_NONE);
    random_cull_volume(KIND_FRUSTUM, VOL_FORMED);
    fork
      begin
        result_hold <= 1'b1;
        repeat (64) @(posedge clk);
        result_hold <= 1'b0;
      end
    join_none
    for (int i = 0; i < 48; i++) send_query(random_query());
    wait_for_results();
    for (int i = 0; i < 16; i++) send_query(random_query());
    wait_for_results();
  endtask

  // Random streams over both cull kinds, all volume styles and idling profiles
  task automatic test_random_streams();
    for (int phase = 0; phase < 8; phase++) begin
      set_idling(idle_profile_t'(phase % 4));
      random_cull_volume((phase >= 4) ? KIND_SPHERE : KIND_FRUSTUM,
                         volume_style_t'(phase % 3));
      for (int i = 0; i < 240; i++) send_query(random_query());
      wait_for_results();
    end
  endtask

  // Check each accepted verdict and pick the next ready
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_visible.size() == 0) begin
          $error("visible: unexpected transaction, actual %0b", result_ch.visible);
          failures++;
        end else begin
          if (result_ch.visible !== expected_visible[0]) begin
            $error("visible: expected %0b, actual %0b", expected_visible[0],
                   result_ch.visible);
            failures++;
          end
          void'(expected_visible.pop_front());
        end
      end
      result_ch.ready <= !result_hold && ($urandom_range(99) >= result_stall_pct);
    end
  end

  // Stop a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    query_ch.valid        = 1'b0;
    query_ch.mode         = MODE_SPHERE;
    query_ch.center_x     = '0;
    query_ch.center_y     = '0;
    query_ch.center_z     = '0;
    query_ch.bound_radius = '0;
    query_ch.lo_x         = '0;
    query_ch.lo_y         = '0;
    query_ch.lo_z         = '0;
    query_ch.hi_x         = '0;
    query_ch.hi_y         = '0;
    query_ch.hi_z         = '0;
    kind_q                = KIND_FRUSTUM;
    sphere_q              = '0;
    for (int p = 0; p < NUM_PLANES; p++) plane_q[p] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_zero_planes();
    test_frustum_cube();
    test_extreme_planes();
    test_light_sphere();
    test_backpressure();
    test_random_streams();
    repeat (SETTLE) @(posedge clk);
    if (failures == 0 && expected_visible.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/vvc_pkg.sv
sv/vvc_channels.sv
sv/vvc_cfg_regs.sv
sv/vvc_prep.sv
sv/vvc_mult.sv
sv/vvc_reduce.sv
sv/view_volume_cull_test_unit.sv
verif/view_volume_cull_test_unit_test.sv
